// File: hw/rtl/sactl_pkg.sv
// ----------------------------------------------------------------------------
// sactl_pkg
// Shared constants, request codes and memory port types for the
// set-associative cache tag array with true LRU replacement.
// ----------------------------------------------------------------------------
`default_nettype none

package sactl_pkg;

    localparam int NUM_SETS    = 64;
    localparam int NUM_WAYS    = 4;
    localparam int BLOCK_BYTES = 64;
    localparam int ADDR_BITS   = 32;

    // Floor of log2, so sizes that are not powers of two still index in range.
    localparam int OFF_BITS       = $clog2(BLOCK_BYTES + 1) - 1;
    localparam int IDX_BITS       = $clog2(NUM_SETS + 1) - 1;
    localparam int TAG_BITS       = ADDR_BITS - OFF_BITS - IDX_BITS;
    localparam int WAY_BITS       = $clog2(NUM_WAYS);
    localparam int RANK_BITS      = WAY_BITS;
    localparam int ROW_BITS       = NUM_WAYS * RANK_BITS;
    localparam int LINE_ADDR_BITS = IDX_BITS + WAY_BITS;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_FILL   = 1'b1;

    typedef struct packed {
        logic                      wr_en;
        logic [LINE_ADDR_BITS-1:0] addr;
        logic [TAG_BITS-1:0]       wdata;
    } tag_req_t;

    typedef struct packed {
        logic                wr_en;
        logic [IDX_BITS-1:0] set;
        logic [ROW_BITS-1:0] wdata;
    } lru_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/sactl_tag_ram.sv
// ----------------------------------------------------------------------------
// sactl_tag_ram
// Tag storage, one entry per line addressed by set and way. Single port,
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sactl_tag_ram
    import sactl_pkg::*;
(
    input  wire logic                aclk,
    input  wire tag_req_t            req,
    output logic [TAG_BITS-1:0]      rdata
);

    logic [TAG_BITS-1:0] mem [NUM_SETS*NUM_WAYS];
    logic [TAG_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/sactl_lru_ram.sv
// ----------------------------------------------------------------------------
// sactl_lru_ram
// Recency ranks, one row per set holding the rank of every way.
// Single port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sactl_lru_ram
    import sactl_pkg::*;
(
    input  wire logic                aclk,
    input  wire lru_req_t            req,
    output logic [ROW_BITS-1:0]      rdata
);

    logic [ROW_BITS-1:0] mem [NUM_SETS];
    logic [ROW_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.set] <= req.wdata;
        end
        rdata_reg <= mem[req.set];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/sactl_ctrl.sv
// ----------------------------------------------------------------------------
// sactl_ctrl
// Request sequencer: walks the ways of one set through a single tag and
// rank compare unit, then updates ranks, tag and valid bits and posts the
// result word.
// ----------------------------------------------------------------------------
`default_nettype none

module sactl_ctrl
    import sactl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [ADDR_BITS-1:0]  s_addr,
    input  wire logic                  s_req_type,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic                       m_hit,
    output logic [WAY_BITS-1:0]        m_way,
    output tag_req_t                   tag_req,
    input  wire logic [TAG_BITS-1:0]   tag_rdata,
    output lru_req_t                   lru_req,
    input  wire logic [ROW_BITS-1:0]   lru_rdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ROW    = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic                 req_reg;
    logic [IDX_BITS-1:0]  set_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [WAY_BITS-1:0]  cnt_reg;
    logic                 found_reg;
    logic [WAY_BITS-1:0]  fway_reg;
    logic [RANK_BITS-1:0] best_reg;
    logic [NUM_WAYS-1:0]  valid_reg [NUM_SETS];
    logic                 m_valid_reg;
    logic                 m_hit_reg;
    logic [WAY_BITS-1:0]  m_way_reg;

    logic                 row_touched;
    logic [ROW_BITS-1:0]  eff_row;
    logic [ROW_BITS-1:0]  new_row;
    logic [RANK_BITS-1:0] cur_rank;
    logic                 cur_valid;
    logic                 match;
    logic                 out_free;
    logic                 accept;

    // A set whose ways were never made valid has never had its ranks
    // changed, so its ranks are still the reset order.
    assign row_touched = |valid_reg[set_reg];

    always_comb begin
        for (int i = 0; i < NUM_WAYS; i++) begin
            eff_row[i*RANK_BITS +: RANK_BITS] =
                row_touched ? lru_rdata[i*RANK_BITS +: RANK_BITS] : RANK_BITS'(i);
        end
    end

    assign cur_rank  = eff_row[cnt_reg*RANK_BITS +: RANK_BITS];
    assign cur_valid = valid_reg[set_reg][cnt_reg];

    // The shared compare unit: a fill looks for the oldest way, a lookup for
    // the most recent valid way holding the tag.
    always_comb begin
        if (req_reg == REQ_FILL) begin
            match = !found_reg && (cur_rank == RANK_BITS'(NUM_WAYS - 1));
        end else begin
            match = cur_valid && (tag_rdata == tag_reg) &&
                    (!found_reg || (cur_rank < best_reg));
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (WAY_BITS'(i) == fway_reg) begin
                new_row[i*RANK_BITS +: RANK_BITS] = '0;
            end else if (eff_row[i*RANK_BITS +: RANK_BITS] < best_reg) begin
                new_row[i*RANK_BITS +: RANK_BITS] =
                    RANK_BITS'(eff_row[i*RANK_BITS +: RANK_BITS] + 1'b1);
            end else begin
                new_row[i*RANK_BITS +: RANK_BITS] = eff_row[i*RANK_BITS +: RANK_BITS];
            end
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        tag_req.wr_en = (state_reg == ST_UPDATE) && out_free && (req_reg == REQ_FILL);
        tag_req.wdata = tag_reg;
        unique case (state_reg)
            ST_SCAN:   tag_req.addr = {set_reg, WAY_BITS'(cnt_reg + 1'b1)};
            ST_UPDATE: tag_req.addr = {set_reg, fway_reg};
            default:   tag_req.addr = {set_reg, {WAY_BITS{1'b0}}};
        endcase
    end

    assign lru_req.wr_en = (state_reg == ST_UPDATE) && out_free && found_reg;
    assign lru_req.set   = set_reg;
    assign lru_req.wdata = new_row;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_ROW;
            ST_ROW:    state_next = ST_SCAN;
            ST_SCAN:   if (cnt_reg == WAY_BITS'(NUM_WAYS - 1)) state_next = ST_UPDATE;
            ST_UPDATE: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int s = 0; s < NUM_SETS; s++) begin
                valid_reg[s] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_UPDATE && out_free) begin
                m_valid_reg <= 1'b1;
                if (req_reg == REQ_FILL) begin
                    valid_reg[set_reg][fway_reg] <= 1'b1;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_req_type;
            set_reg <= s_addr[OFF_BITS +: IDX_BITS];
            tag_reg <= s_addr[OFF_BITS + IDX_BITS +: TAG_BITS];
        end
        if (state_reg == ST_ROW) begin
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            fway_reg  <= '0;
            best_reg  <= '0;
        end else if (state_reg == ST_SCAN) begin
            cnt_reg <= WAY_BITS'(cnt_reg + 1'b1);
            if (match) begin
                found_reg <= 1'b1;
                fway_reg  <= cnt_reg;
                best_reg  <= cur_rank;
            end
        end
        if (state_reg == ST_UPDATE && out_free) begin
            m_hit_reg <= (req_reg == REQ_LOOKUP) && found_reg;
            m_way_reg <= found_reg ? fway_reg : '0;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_hit    = m_hit_reg;
    assign m_way    = m_way_reg;

endmodule

`default_nettype wire

// File: hw/rtl/set_assoc_cache_tag_lru_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_top
// Tag array of a 64-set, 4-way cache with true LRU replacement.
// ----------------------------------------------------------------------------
// Each input word is a lookup (tuser 0) or a fill (tuser 1) for a 32-bit
// byte address; each produces exactly one result word giving the hit flag
// (tuser) and the way (tdata). A request reads the set's rank row, passes
// each way in turn through the single tag and rank comparator, then writes
// back the ranks after a hit or fill and, for a fill, the tag and valid bit
// before the result is offered. The input is not ready while a request is
// in progress, and a request holds at write-back while an earlier result waits.
// Valid bits clear in the reset cycle; no clearing pass is needed.
`default_nettype none

module set_assoc_cache_tag_lru_top
    import sactl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] addr
    input  wire logic        s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [1:0] way, [7:2] zero
    output logic             m_tuser    // [0] hit
);

    tag_req_t            tag_req;
    lru_req_t            lru_req;
    logic [TAG_BITS-1:0] tag_rdata;
    logic [ROW_BITS-1:0] lru_rdata;
    logic [WAY_BITS-1:0] way;

    sactl_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_addr     (s_tdata),
        .s_req_type (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_hit      (m_tuser),
        .m_way      (way),
        .tag_req    (tag_req),
        .tag_rdata  (tag_rdata),
        .lru_req    (lru_req),
        .lru_rdata  (lru_rdata)
    );

    sactl_tag_ram u_tag_ram (
        .aclk  (aclk),
        .req   (tag_req),
        .rdata (tag_rdata)
    );

    sactl_lru_ram u_lru_ram (
        .aclk  (aclk),
        .req   (lru_req),
        .rdata (lru_rdata)
    );

    assign m_tdata = {{(8 - WAY_BITS){1'b0}}, way};

endmodule

`default_nettype wire

// File: hw/rtl/sactl_checker.sv
// ----------------------------------------------------------------------------
// sactl_checker
// Port-level checks of the tag array: busy window after a request, result
// ordering against requests, output stall behavior and reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sactl_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tuser
);

    // An accepted request keeps the input not ready before the next word is taken.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input accepted again too soon after a request");

    // A new result appears only as the block finishes a request.
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result word appeared without a request in progress");

    // The way field never uses bits above the way index.
    a_tdata_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:2] == 6'd0))
        else $error("result padding bits are not zero");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed or was dropped");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind set_assoc_cache_tag_lru_top sactl_checker u_sactl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
